### rtl/midpoint_line_rasterizer_macros.svh
// Assertion macros for the midpoint line rasterizer.
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mlr_pkg.sv
// Shared types and codes for the midpoint line rasterizer.
`default_nettype none

package mlr_pkg;

    typedef enum logic [1:0] {
        OCT_SHALLOW_RISE = 2'd0,
        OCT_SHALLOW_FALL = 2'd1,
        OCT_STEEP_RISE   = 2'd2,
        OCT_STEEP_FALL   = 2'd3
    } t_octant;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

endpackage

`default_nettype wire

### rtl/mlr_setup.sv
// Line setup: endpoint ordering, octant choice, initial decision and increments.
`default_nettype none

module mlr_setup
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    localparam int DEC_BITS = COORD_BITS + 4
) (
    input  logic [COORD_BITS-1:0]      i_start_x,
    input  logic [COORD_BITS-1:0]      i_start_y,
    input  logic [COORD_BITS-1:0]      i_end_x,
    input  logic [COORD_BITS-1:0]      i_end_y,
    output logic [COORD_BITS-1:0]      o_first_x,
    output logic [COORD_BITS-1:0]      o_first_y,
    output logic [COORD_BITS-1:0]      o_stop,
    output logic signed [DEC_BITS-1:0] o_decision,
    output logic signed [DEC_BITS-1:0] o_step_axial,
    output logic signed [DEC_BITS-1:0] o_step_diagonal,
    output t_octant                    o_octant,
    output logic                       o_last
);

    localparam int EXT_BITS = DEC_BITS - COORD_BITS;

    logic                       w_swap;
    logic [COORD_BITS-1:0]      w_xa;
    logic [COORD_BITS-1:0]      w_ya;
    logic [COORD_BITS-1:0]      w_xb;
    logic [COORD_BITS-1:0]      w_yb;
    logic signed [DEC_BITS-1:0] w_dx;
    logic signed [DEC_BITS-1:0] w_dy;
    logic signed [DEC_BITS-1:0] w_dx2;
    logic signed [DEC_BITS-1:0] w_dy2;
    logic signed [DEC_BITS-1:0] w_ady;
    logic                       w_shallow;

    assign w_swap = i_start_x > i_end_x;
    assign w_xa   = w_swap ? i_end_x   : i_start_x;
    assign w_ya   = w_swap ? i_end_y   : i_start_y;
    assign w_xb   = w_swap ? i_start_x : i_end_x;
    assign w_yb   = w_swap ? i_start_y : i_end_y;

    assign w_dx  = $signed({{EXT_BITS{1'b0}}, w_xb}) - $signed({{EXT_BITS{1'b0}}, w_xa});
    assign w_dy  = $signed({{EXT_BITS{1'b0}}, w_yb}) - $signed({{EXT_BITS{1'b0}}, w_ya});
    assign w_dx2 = w_dx <<< 1;
    assign w_dy2 = w_dy <<< 1;
    assign w_ady = w_dy[DEC_BITS-1] ? -w_dy : w_dy;

    assign w_shallow = w_dx >= w_ady;

    assign o_first_x = w_xa;
    assign o_first_y = w_ya;
    assign o_stop    = w_shallow ? w_xb : w_yb;
    assign o_last    = w_shallow ? (w_xa == w_xb) : (w_ya == w_yb);

    always_comb begin
        if (w_shallow) begin
            o_octant = w_dy[DEC_BITS-1] ? OCT_SHALLOW_FALL : OCT_SHALLOW_RISE;
        end else begin
            o_octant = w_dy[DEC_BITS-1] ? OCT_STEEP_FALL : OCT_STEEP_RISE;
        end
    end

    always_comb begin
        unique case (o_octant)
            OCT_SHALLOW_RISE: begin
                o_decision      = w_dy2 - w_dx;
                o_step_axial    = w_dy2;
                o_step_diagonal = w_dy2 - w_dx2;
            end
            OCT_SHALLOW_FALL: begin
                o_decision      = w_dy2 + w_dx;
                o_step_axial    = w_dy2;
                o_step_diagonal = w_dy2 + w_dx2;
            end
            OCT_STEEP_RISE: begin
                o_decision      = w_dy - w_dx2;
                o_step_axial    = -w_dx2;
                o_step_diagonal = w_dy2 - w_dx2;
            end
            default: begin
                o_decision      = w_dy + w_dx2;
                o_step_axial    = w_dx2;
                o_step_diagonal = w_dy2 + w_dx2;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/mlr_step.sv
// One rasterizer step: next pixel, next decision value and end-of-line flag.
`default_nettype none

module mlr_step
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    localparam int DEC_BITS = COORD_BITS + 4
) (
    input  logic [COORD_BITS-1:0]      i_cur_x,
    input  logic [COORD_BITS-1:0]      i_cur_y,
    input  logic [COORD_BITS-1:0]      i_stop,
    input  logic signed [DEC_BITS-1:0] i_decision,
    input  logic signed [DEC_BITS-1:0] i_step_axial,
    input  logic signed [DEC_BITS-1:0] i_step_diagonal,
    input  t_octant                    i_octant,
    output logic [COORD_BITS-1:0]      o_next_x,
    output logic [COORD_BITS-1:0]      o_next_y,
    output logic signed [DEC_BITS-1:0] o_next_decision,
    output logic                       o_last
);

    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    logic w_axial;
    logic w_pos;
    logic w_neg;

    assign w_neg = i_decision[DEC_BITS-1];
    assign w_pos = !w_neg && (i_decision != '0);

    always_comb begin
        unique case (i_octant)
            OCT_SHALLOW_RISE: begin
                w_axial  = !w_pos;
                o_next_x = i_cur_x + ONE;
                o_next_y = w_axial ? i_cur_y : i_cur_y + ONE;
                o_last   = o_next_x == i_stop;
            end
            OCT_SHALLOW_FALL: begin
                w_axial  = !w_neg;
                o_next_x = i_cur_x + ONE;
                o_next_y = w_axial ? i_cur_y : i_cur_y - ONE;
                o_last   = o_next_x == i_stop;
            end
            OCT_STEEP_RISE: begin
                w_axial  = !w_neg;
                o_next_x = w_axial ? i_cur_x : i_cur_x + ONE;
                o_next_y = i_cur_y + ONE;
                o_last   = o_next_y == i_stop;
            end
            default: begin
                w_axial  = !w_pos;
                o_next_x = w_axial ? i_cur_x : i_cur_x + ONE;
                o_next_y = i_cur_y - ONE;
                o_last   = o_next_y == i_stop;
            end
        endcase
    end

    assign o_next_decision = i_decision + (w_axial ? i_step_axial : i_step_diagonal);

endmodule

`default_nettype wire

### rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer top level: input register, line state, result register.
// Items wait in the input register; each pixel enters the result register once it is free.
// One item per cycle unless stalled; each step is one decision add and one coordinate compare.
// A stalled result holds the pipe while the input register still takes one more item.
// Reset (i_rst_n low, synchronous) empties both registers and ends any active line.
`default_nettype none

`include "midpoint_line_rasterizer_macros.svh"

module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // action
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // last_pixel
    output logic                                    m_axis_tlast
);

    localparam int DEC_BITS  = COORD_BITS + 4;
    localparam int OUT_BITS  = ((2*COORD_BITS+7)/8)*8;

    logic                       r_in_valid;
    logic                       r_in_action;
    logic [COORD_BITS-1:0]      r_in_start_x;
    logic [COORD_BITS-1:0]      r_in_start_y;
    logic [COORD_BITS-1:0]      r_in_end_x;
    logic [COORD_BITS-1:0]      r_in_end_y;

    logic                       r_active;
    logic [COORD_BITS-1:0]      r_cur_x;
    logic [COORD_BITS-1:0]      r_cur_y;
    logic [COORD_BITS-1:0]      r_stop;
    logic signed [DEC_BITS-1:0] r_decision;
    logic signed [DEC_BITS-1:0] r_step_axial;
    logic signed [DEC_BITS-1:0] r_step_diagonal;
    t_octant                    r_octant;

    logic                       r_out_valid;
    logic [COORD_BITS-1:0]      r_out_x;
    logic [COORD_BITS-1:0]      r_out_y;
    logic                       r_out_last;

    logic                       n_active;
    logic [COORD_BITS-1:0]      n_cur_x;
    logic [COORD_BITS-1:0]      n_cur_y;
    logic [COORD_BITS-1:0]      n_stop;
    logic signed [DEC_BITS-1:0] n_decision;
    logic signed [DEC_BITS-1:0] n_step_axial;
    logic signed [DEC_BITS-1:0] n_step_diagonal;
    t_octant                    n_octant;
    logic                       n_out_last;

    logic                       w_fire;
    logic                       w_start;
    logic                       w_emit;

    logic [COORD_BITS-1:0]      w_setup_x;
    logic [COORD_BITS-1:0]      w_setup_y;
    logic [COORD_BITS-1:0]      w_setup_stop;
    logic signed [DEC_BITS-1:0] w_setup_decision;
    logic signed [DEC_BITS-1:0] w_setup_axial;
    logic signed [DEC_BITS-1:0] w_setup_diagonal;
    t_octant                    w_setup_octant;
    logic                       w_setup_last;

    logic [COORD_BITS-1:0]      w_step_x;
    logic [COORD_BITS-1:0]      w_step_y;
    logic signed [DEC_BITS-1:0] w_step_decision;
    logic                       w_step_last;

    assign w_fire  = r_in_valid && (!r_out_valid || m_axis_tready);
    assign w_start = r_in_action == ACT_START;
    assign w_emit  = w_start || r_active;

    assign s_axis_tready = !r_in_valid || w_fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_BITS'({r_out_y, r_out_x});
    assign m_axis_tlast  = r_out_last;

    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start_x       (r_in_start_x),
        .i_start_y       (r_in_start_y),
        .i_end_x         (r_in_end_x),
        .i_end_y         (r_in_end_y),
        .o_first_x       (w_setup_x),
        .o_first_y       (w_setup_y),
        .o_stop          (w_setup_stop),
        .o_decision      (w_setup_decision),
        .o_step_axial    (w_setup_axial),
        .o_step_diagonal (w_setup_diagonal),
        .o_octant        (w_setup_octant),
        .o_last          (w_setup_last)
    );

    mlr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_cur_x         (r_cur_x),
        .i_cur_y         (r_cur_y),
        .i_stop          (r_stop),
        .i_decision      (r_decision),
        .i_step_axial    (r_step_axial),
        .i_step_diagonal (r_step_diagonal),
        .i_octant        (r_octant),
        .o_next_x        (w_step_x),
        .o_next_y        (w_step_y),
        .o_next_decision (w_step_decision),
        .o_last          (w_step_last)
    );

    always_comb begin
        n_active        = r_active;
        n_cur_x         = r_cur_x;
        n_cur_y         = r_cur_y;
        n_stop          = r_stop;
        n_decision      = r_decision;
        n_step_axial    = r_step_axial;
        n_step_diagonal = r_step_diagonal;
        n_octant        = r_octant;
        n_out_last      = w_step_last;
        if (w_fire && w_start) begin
            n_active        = !w_setup_last;
            n_cur_x         = w_setup_x;
            n_cur_y         = w_setup_y;
            n_stop          = w_setup_stop;
            n_decision      = w_setup_decision;
            n_step_axial    = w_setup_axial;
            n_step_diagonal = w_setup_diagonal;
            n_octant        = w_setup_octant;
            n_out_last      = w_setup_last;
        end else if (w_fire && r_active) begin
            n_active   = !w_step_last;
            n_cur_x    = w_step_x;
            n_cur_y    = w_step_y;
            n_decision = w_step_decision;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_active        <= 1'b0;
            r_cur_x         <= '0;
            r_cur_y         <= '0;
            r_stop          <= '0;
            r_decision      <= '0;
            r_step_axial    <= '0;
            r_step_diagonal <= '0;
            r_octant        <= OCT_SHALLOW_RISE;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_fire) begin
                r_out_valid <= w_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_active        <= n_active;
            r_cur_x         <= n_cur_x;
            r_cur_y         <= n_cur_y;
            r_stop          <= n_stop;
            r_decision      <= n_decision;
            r_step_axial    <= n_step_axial;
            r_step_diagonal <= n_step_diagonal;
            r_octant        <= n_octant;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action  <= s_axis_tuser;
            r_in_start_x <= s_axis_tdata[COORD_BITS-1:0];
            r_in_start_y <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            r_in_end_x   <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
            r_in_end_y   <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
        end
        if (w_fire && w_emit) begin
            r_out_x    <= n_cur_x;
            r_out_y    <= n_cur_y;
            r_out_last <= n_out_last;
        end
    end

    `MLR_ASSERT_NEXT(a_last_ends_line, w_fire && w_emit && n_out_last, !r_active,
        "line still active after its last pixel")
    `MLR_ASSERT_NEXT(a_idle_advance_silent, w_fire && !w_emit, !r_out_valid,
        "advance without an active line produced a pixel")
    `MLR_ASSERT_NEXT(a_in_held_on_stall, r_in_valid && !w_fire,
        r_in_valid && $stable(r_in_start_x) && $stable(r_in_end_y),
        "stalled input item was lost or overwritten")
    `MLR_ASSERT_NOW(a_shallow_not_at_stop,
        r_active && (r_octant == OCT_SHALLOW_RISE || r_octant == OCT_SHALLOW_FALL),
        r_cur_x != r_stop, "active shallow line already at its end x")
    `MLR_ASSERT_NOW(a_steep_not_at_stop,
        r_active && (r_octant == OCT_STEEP_RISE || r_octant == OCT_STEEP_FALL),
        r_cur_y != r_stop, "active steep line already at its end y")

endmodule

`default_nettype wire
